// File: sv/tetra_affine_inverse_and_volume_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tetrahedron inverse block
// Implication checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef TETRA_AFFINE_INVERSE_AND_VOLUME_MACROS_SVH
`define TETRA_AFFINE_INVERSE_AND_VOLUME_MACROS_SVH
`ifndef SYNTHESIS
`define TAVI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tavi: same-cycle check failed");
`define TAVI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tavi: next-cycle check failed");
`else
`define TAVI_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TAVI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/tavi_pkg.sv
// ----------------------------------------------------------------------------
// tavi_pkg
// Widths, constants and types shared by the tetrahedron inverse block.
// ----------------------------------------------------------------------------
package tavi_pkg;
   localparam int COORD_WIDTH = 16;
   localparam int COORD_FRAC  = 8;
   localparam int OUT_WIDTH   = 32;
   localparam int OUT_FRAC    = OUT_WIDTH / 2;
   localparam int VOL_WIDTH   = 52;

   localparam int EDGE_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int ADJ_W   = PROD_W + 1;
   localparam int DP_W    = EDGE_W + ADJ_W;
   localparam int DET_W   = DP_W + 2;
   localparam int BP_W    = ADJ_W + COORD_WIDTH;
   localparam int BN_W    = BP_W + 2;
   localparam int A_SHIFT = COORD_FRAC + OUT_FRAC;
   localparam int NUM_W   = (ADJ_W + A_SHIFT > BN_W + OUT_FRAC) ?
                            (ADJ_W + A_SHIFT) : (BN_W + OUT_FRAC);

   // divider lanes: one quotient bit per stage
   localparam int QB       = OUT_WIDTH + 1;
   localparam int REM_W    = DET_W + 1;
   localparam int LANE_LAT = QB + 2;

   // volume: (|det|/2)/3 as a multiply by ceil(2^52/3) and a shift by 52;
   // exact while |det|/2 < 2^51, and |det| stays below 2^51
   localparam int VOL_X_W = 52;
   localparam int VOL_H_W = VOL_X_W / 2;
   localparam logic [VOL_X_W-1:0] VOL_RECIP = 52'h5555555555556;

   localparam int FRONT_LAT = 5;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam int ROW_W = 2;
   localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(0);
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(2);

   typedef struct packed {
      logic [2:0][2:0][ADJ_W-1:0] adj;
      logic [2:0][BN_W-1:0]       bn;
      logic [DET_W-1:0]           det;
   } work_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;
endpackage

// File: sv/tavi_div_lane.sv
// ----------------------------------------------------------------------------
// tavi_div_lane
// Pipelined restoring divider: round(num / den), clamped to OUT_WIDTH signed.
// ----------------------------------------------------------------------------
module tavi_div_lane (
   input  logic                               clock,
   input  logic [tavi_pkg::NUM_W-1:0]         in_num,
   input  logic [tavi_pkg::DET_W-1:0]         in_den,
   input  logic                               in_neg,
   output logic [tavi_pkg::OUT_WIDTH-1:0]     out_value,
   output logic                               out_sat
);
   localparam int QB    = tavi_pkg::QB;
   localparam int REM_W = tavi_pkg::REM_W;
   localparam int OW    = tavi_pkg::OUT_WIDTH;
   localparam logic [QB:0] MAXP = (QB+1)'((64'd1 << (OW - 1)) - 64'd1);

   logic [REM_W-1:0]           rem_ff [0:QB];
   logic [QB-1:0]              lq_ff  [0:QB];
   logic [tavi_pkg::DET_W-1:0] den_ff [0:QB];
   logic                       neg_ff [0:QB];
   logic                       ovf_ff [0:QB];
   logic [OW-1:0]              value_ff, value_in;
   logic                       sat_ff, sat_in;
   logic                       rnd;
   logic [QB:0]                q1;

   // quotient must fit QB bits, else it saturates
   always_ff @(posedge clock) begin
      rem_ff[0] <= REM_W'(in_num[tavi_pkg::NUM_W-1:QB]);
      lq_ff[0]  <= in_num[QB-1:0];
      den_ff[0] <= in_den;
      neg_ff[0] <= in_neg;
      ovf_ff[0] <= REM_W'(in_num[tavi_pkg::NUM_W-1:QB]) >= REM_W'(in_den);
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [REM_W-1:0] trial;
      logic             take;
      assign trial = {rem_ff[k-1][REM_W-2:0], lq_ff[k-1][QB-1]};
      assign take  = trial >= REM_W'(den_ff[k-1]);
      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? trial - REM_W'(den_ff[k-1]) : trial;
         lq_ff[k]  <= {lq_ff[k-1][QB-2:0], take};
         den_ff[k] <= den_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   always_comb begin
      rnd = {rem_ff[QB], 1'b0} >= (REM_W+1)'(den_ff[QB]);
      q1  = (QB+1)'(lq_ff[QB]) + (QB+1)'(rnd);
      if (neg_ff[QB]) begin
         sat_in   = ovf_ff[QB] || (q1 > MAXP + (QB+1)'(1));
         value_in = sat_in ? {1'b1, (OW-1)'(0)} : OW'(~q1[OW-1:0] + OW'(1));
      end else begin
         sat_in   = ovf_ff[QB] || (q1 > MAXP);
         value_in = sat_in ? MAXP[OW-1:0] : q1[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign out_value = value_ff;
   assign out_sat   = sat_ff;
endmodule

// File: sv/tavi_fifo.sv
// ----------------------------------------------------------------------------
// tavi_fifo
// Short queue of prepared transactions between front and back.
// ----------------------------------------------------------------------------
module tavi_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tavi_pkg::work_type        push_data,
   input  logic                      pop,
   output tavi_pkg::work_type        head,
   output tavi_pkg::fifo_status_type status
);
   tavi_pkg::work_type             mem_ff [tavi_pkg::QDEPTH];
   logic [tavi_pkg::QPTR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [tavi_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + tavi_pkg::QPTR_W'(1) : wp_ff;
      rp_in  = pop ? rp_ff + tavi_pkg::QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + tavi_pkg::QCNT_W'(push) - tavi_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rp_ff];
   assign status.empty = cnt_ff == '0;
   assign status.full  = cnt_ff == tavi_pkg::QCNT_W'(tavi_pkg::QDEPTH);
endmodule

// File: sv/tavi_front.sv
// ----------------------------------------------------------------------------
// tavi_front
// Accepts vertices; forms edges, adjugate, determinant and offset numerators.
// ----------------------------------------------------------------------------
module tavi_front (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic [3:0][2:0][tavi_pkg::COORD_WIDTH-1:0]    vert,
   input  logic                                          pop,
   output logic                                          push,
   output tavi_pkg::work_type                            push_data
);
   localparam int EW = tavi_pkg::EDGE_W;
   localparam int PW = tavi_pkg::PROD_W;
   localparam int AW = tavi_pkg::ADJ_W;
   localparam int CW = tavi_pkg::COORD_WIDTH;

   // credits count transactions accepted and not yet taken by the back end
   logic [tavi_pkg::QCNT_W-1:0]    credit_ff, credit_in;
   logic [tavi_pkg::FRONT_LAT-1:0] vld_ff, vld_in;
   logic                           accept;

   logic signed [EW-1:0]              e_ff   [3][3];
   logic signed [CW-1:0]              v0_ff  [3];
   logic signed [PW-1:0]              pa_ff  [3][3];
   logic signed [PW-1:0]              pb_ff  [3][3];
   logic signed [EW-1:0]              e0_ff2 [3];
   logic signed [CW-1:0]              v0_ff2 [3];
   logic signed [AW-1:0]              adj_ff [3][3];
   logic signed [EW-1:0]              e0_ff3 [3];
   logic signed [CW-1:0]              v0_ff3 [3];
   logic signed [tavi_pkg::DP_W-1:0]  dp_ff  [3];
   logic signed [tavi_pkg::BP_W-1:0]  bp_ff  [3][3];
   logic signed [AW-1:0]              adj_ff4 [3][3];
   logic signed [tavi_pkg::DET_W-1:0] det_ff;
   logic signed [tavi_pkg::BN_W-1:0]  bn_ff  [3];
   logic signed [AW-1:0]              adj_ff5 [3][3];

   assign busy   = credit_ff == tavi_pkg::QCNT_W'(tavi_pkg::QDEPTH);
   assign accept = start && !busy;

   always_comb begin
      credit_in = credit_ff + tavi_pkg::QCNT_W'(accept) - tavi_pkg::QCNT_W'(pop);
      vld_in    = {vld_ff[tavi_pkg::FRONT_LAT-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         vld_ff    <= '0;
      end else begin
         credit_ff <= credit_in;
         vld_ff    <= vld_in;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_edge
      for (genvar c = 0; c < 3; c++) begin : g_col
         always_ff @(posedge clock) begin
            e_ff[r][c] <= EW'(signed'(vert[c+1][r])) - EW'(signed'(vert[0][r]));
         end
      end
      always_ff @(posedge clock) begin
         v0_ff[r]  <= signed'(vert[0][r]);
         e0_ff2[r] <= e_ff[0][r];
         v0_ff2[r] <= v0_ff[r];
         e0_ff3[r] <= e0_ff2[r];
         v0_ff3[r] <= v0_ff2[r];
      end
   end

   // adj[i][j] = e[j+1][i+1]*e[j+2][i+2] - e[j+1][i+2]*e[j+2][i+1], indices mod 3
   for (genvar i = 0; i < 3; i++) begin : g_adj
      for (genvar j = 0; j < 3; j++) begin : g_adjc
         localparam int J1 = (j + 1) % 3;
         localparam int J2 = (j + 2) % 3;
         localparam int I1 = (i + 1) % 3;
         localparam int I2 = (i + 2) % 3;
         always_ff @(posedge clock) begin
            pa_ff[i][j]   <= PW'(e_ff[J1][I1]) * PW'(e_ff[J2][I2]);
            pb_ff[i][j]   <= PW'(e_ff[J1][I2]) * PW'(e_ff[J2][I1]);
            adj_ff[i][j]  <= AW'(pa_ff[i][j]) - AW'(pb_ff[i][j]);
            bp_ff[i][j]   <= tavi_pkg::BP_W'(adj_ff[i][j]) * tavi_pkg::BP_W'(v0_ff3[j]);
            adj_ff4[i][j] <= adj_ff[i][j];
            adj_ff5[i][j] <= adj_ff4[i][j];
         end
      end
      always_ff @(posedge clock) begin
         dp_ff[i] <= tavi_pkg::DP_W'(e0_ff3[i]) * tavi_pkg::DP_W'(adj_ff[i][0]);
         bn_ff[i] <= tavi_pkg::BN_W'(0) - (tavi_pkg::BN_W'(bp_ff[i][0]) +
                     tavi_pkg::BN_W'(bp_ff[i][1]) + tavi_pkg::BN_W'(bp_ff[i][2]));
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= tavi_pkg::DET_W'(dp_ff[0]) + tavi_pkg::DET_W'(dp_ff[1]) +
                tavi_pkg::DET_W'(dp_ff[2]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            push_data.adj[i][j] = adj_ff5[i][j];
         end
         push_data.bn[i] = bn_ff[i];
      end
      push_data.det = det_ff;
   end

   assign push = vld_ff[tavi_pkg::FRONT_LAT-1];
endmodule

// File: sv/tavi_back.sv
// ----------------------------------------------------------------------------
// tavi_back
// Issues three rows per transaction into four divider lanes; forms volume.
// ----------------------------------------------------------------------------
module tavi_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tavi_pkg::work_type                    head,
   input  tavi_pkg::fifo_status_type             q_status,
   output logic                                  pop,
   output logic                                  rsp_valid,
   output logic [tavi_pkg::ROW_W-1:0]            rsp_row_index,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0] rsp_inv_col0,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0] rsp_inv_col1,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0] rsp_inv_col2,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0] rsp_offset,
   output logic signed [tavi_pkg::VOL_WIDTH-1:0] rsp_signed_volume,
   output logic                                  rsp_degenerate,
   output logic                                  rsp_saturated,
   output logic                                  rsp_last
);
   localparam int LAT = tavi_pkg::LANE_LAT;
   localparam int AW  = tavi_pkg::ADJ_W;
   localparam int BW  = tavi_pkg::BN_W;
   localparam int DW  = tavi_pkg::DET_W;
   localparam int NW  = tavi_pkg::NUM_W;
   localparam int VX  = tavi_pkg::VOL_X_W;
   localparam int HW  = tavi_pkg::VOL_H_W;
   localparam logic [HW-1:0] RECIP_HI = tavi_pkg::VOL_RECIP[VX-1:HW];
   localparam logic [HW-1:0] RECIP_LO = tavi_pkg::VOL_RECIP[HW-1:0];

   function automatic logic [AW-1:0] mag_adj(input logic [AW-1:0] a);
      return a[AW-1] ? ~a + AW'(1) : a;
   endfunction
   function automatic logic [BW-1:0] mag_bn(input logic [BW-1:0] a);
      return a[BW-1] ? ~a + BW'(1) : a;
   endfunction
   function automatic logic [DW-1:0] mag_det(input logic [DW-1:0] a);
      return a[DW-1] ? ~a + DW'(1) : a;
   endfunction

   logic [tavi_pkg::ROW_W-1:0] rc_ff, rc_in;
   logic                       issue;
   logic [2:0][AW-1:0]         sel_adj;
   logic [BW-1:0]              sel_bn;

   logic                       iss_valid_ff;
   logic [tavi_pkg::ROW_W-1:0] iss_row_ff;
   logic [NW-1:0]              iss_num_ff [4];
   logic                       iss_neg_ff [4];
   logic [DW-1:0]              iss_den_ff;
   logic                       iss_dneg_ff;
   logic                       iss_zero_ff;

   logic [tavi_pkg::OUT_WIDTH-1:0] lane_val [4];
   logic                           lane_sat [4];

   logic                       sv_ff   [1:LAT];
   logic [tavi_pkg::ROW_W-1:0] row_ff  [1:LAT];
   logic                       zero_ff [1:LAT];
   logic                       dneg_ff [1:LAT];
   logic [VX-1:0]              vx_ff   [1:LAT-3];
   logic [HW-1:0]              vx_hi, vx_lo;
   logic [2*HW-1:0]            pp_ff   [4];
   logic [2*VX-1:0]            vsum;
   logic [VX-1:0]              vq_ff;
   logic [tavi_pkg::VOL_WIDTH-1:0] vol_ff;

   // rows of one transaction go out on consecutive cycles
   assign issue = !q_status.empty;
   assign pop   = issue && (rc_ff == tavi_pkg::ROW_LAST);

   always_comb begin
      if (!issue) begin
         rc_in = rc_ff;
      end else if (rc_ff == tavi_pkg::ROW_LAST) begin
         rc_in = tavi_pkg::ROW_FIRST;
      end else begin
         rc_in = rc_ff + tavi_pkg::ROW_W'(1);
      end
   end

   always_comb begin
      case (rc_ff)
         2'd1: begin
            sel_adj = head.adj[1];
            sel_bn  = head.bn[1];
         end
         2'd2: begin
            sel_adj = head.adj[2];
            sel_bn  = head.bn[2];
         end
         default: begin
            sel_adj = head.adj[0];
            sel_bn  = head.bn[0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff        <= tavi_pkg::ROW_FIRST;
         iss_valid_ff <= 1'b0;
      end else begin
         rc_ff        <= rc_in;
         iss_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         iss_num_ff[j] <= NW'(mag_adj(sel_adj[j])) << tavi_pkg::A_SHIFT;
         iss_neg_ff[j] <= sel_adj[j][AW-1] ^ head.det[DW-1];
      end
      iss_num_ff[3] <= NW'(mag_bn(sel_bn)) << tavi_pkg::OUT_FRAC;
      iss_neg_ff[3] <= sel_bn[BW-1] ^ head.det[DW-1];
      iss_den_ff    <= mag_det(head.det);
      iss_dneg_ff   <= head.det[DW-1];
      iss_zero_ff   <= head.det == '0;
      iss_row_ff    <= rc_ff;
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      tavi_div_lane u_lane (
         .clock     (clock),
         .in_num    (iss_num_ff[l]),
         .in_den    (iss_den_ff),
         .in_neg    (iss_neg_ff[l]),
         .out_value (lane_val[l]),
         .out_sat   (lane_sat[l])
      );
   end

   // side pipe, aligned with the lanes; |det|/2 rides along until the
   // reciprocal multiply and sign in the last three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[1] <= 1'b0;
      end else begin
         sv_ff[1] <= iss_valid_ff;
      end
      row_ff[1]  <= iss_row_ff;
      zero_ff[1] <= iss_zero_ff;
      dneg_ff[1] <= iss_dneg_ff;
      vx_ff[1]   <= VX'(iss_den_ff >> 1);
   end

   for (genvar k = 2; k <= LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else begin
            sv_ff[k] <= sv_ff[k-1];
         end
         row_ff[k]  <= row_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
         dneg_ff[k] <= dneg_ff[k-1];
      end
      if (k <= LAT - 3) begin : g_vx
         always_ff @(posedge clock) begin
            vx_ff[k] <= vx_ff[k-1];
         end
      end
   end

   // split 26 x 26 partial products, then sum and keep the top half
   assign vx_hi = vx_ff[LAT-3][VX-1:HW];
   assign vx_lo = vx_ff[LAT-3][HW-1:0];

   always_comb begin
      vsum = {pp_ff[0], VX'(0)} +
             (((2*VX)'(pp_ff[1]) + (2*VX)'(pp_ff[2])) << HW) +
             (2*VX)'(pp_ff[3]);
   end

   always_ff @(posedge clock) begin
      pp_ff[0] <= (2*HW)'(vx_hi) * (2*HW)'(RECIP_HI);
      pp_ff[1] <= (2*HW)'(vx_hi) * (2*HW)'(RECIP_LO);
      pp_ff[2] <= (2*HW)'(vx_lo) * (2*HW)'(RECIP_HI);
      pp_ff[3] <= (2*HW)'(vx_lo) * (2*HW)'(RECIP_LO);
      vq_ff    <= vsum[2*VX-1:VX];
   end

   // |det|/6 stays well inside the volume range
   always_ff @(posedge clock) begin
      vol_ff <= dneg_ff[LAT-1] ? tavi_pkg::VOL_WIDTH'(~vq_ff + VX'(1))
                               : tavi_pkg::VOL_WIDTH'(vq_ff);
   end

   assign rsp_valid         = sv_ff[LAT];
   assign rsp_row_index     = row_ff[LAT];
   assign rsp_last          = row_ff[LAT] == tavi_pkg::ROW_LAST;
   assign rsp_degenerate    = zero_ff[LAT];
   assign rsp_inv_col0      = zero_ff[LAT] ? '0 : signed'(lane_val[0]);
   assign rsp_inv_col1      = zero_ff[LAT] ? '0 : signed'(lane_val[1]);
   assign rsp_inv_col2      = zero_ff[LAT] ? '0 : signed'(lane_val[2]);
   assign rsp_offset        = zero_ff[LAT] ? '0 : signed'(lane_val[3]);
   assign rsp_signed_volume = signed'(vol_ff);
   assign rsp_saturated     = !zero_ff[LAT] &&
                              (lane_sat[0] || lane_sat[1] || lane_sat[2] || lane_sat[3]);
endmodule

// File: sv/tetra_affine_inverse_and_volume.sv
// ----------------------------------------------------------------------------
// tetra_affine_inverse_and_volume
// Inverse edge matrix, offset and signed volume of a tetrahedron.
//
// channel   dir  handshake              payload
// request   in   start && !busy         req_v0_x .. req_v3_z (Q8.8)
// response  out  rsp_valid, one cycle   row, inverse row, offset, volume, flags
//
// Each transaction gives three response rows on consecutive cycles; the
// sustained rate is set by the single response port that the four divider
// lanes feed one row at a time. The first row passes through the 5 front
// stages, the first clocked by the accepting edge, the queue write, the issue
// register and 35 lane stages including the lane output register. Up to four
// transactions are taken back to back; busy then paces start to the back end.
// Synchronous reset clears all control state; the receiver cannot stall, so
// nothing waits on the output.
// ----------------------------------------------------------------------------
`include "tetra_affine_inverse_and_volume_macros.svh"

module tetra_affine_inverse_and_volume (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v0_x,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v0_y,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v0_z,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v1_x,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v1_y,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v1_z,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v2_x,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v2_y,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v2_z,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v3_x,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v3_y,
   input  logic signed [tavi_pkg::COORD_WIDTH-1:0] req_v3_z,
   output logic                                    rsp_valid,
   output logic [tavi_pkg::ROW_W-1:0]              rsp_row_index,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0]   rsp_inv_col0,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0]   rsp_inv_col1,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0]   rsp_inv_col2,
   output logic signed [tavi_pkg::OUT_WIDTH-1:0]   rsp_offset,
   output logic signed [tavi_pkg::VOL_WIDTH-1:0]   rsp_signed_volume,
   output logic                                    rsp_degenerate,
   output logic                                    rsp_saturated,
   output logic                                    rsp_last
);
   logic [3:0][2:0][tavi_pkg::COORD_WIDTH-1:0] vert;
   logic                      push, pop;
   tavi_pkg::work_type        push_data, head;
   tavi_pkg::fifo_status_type q_status;

   assign vert[0] = {req_v0_z, req_v0_y, req_v0_x};
   assign vert[1] = {req_v1_z, req_v1_y, req_v1_x};
   assign vert[2] = {req_v2_z, req_v2_y, req_v2_x};
   assign vert[3] = {req_v3_z, req_v3_y, req_v3_x};

   tavi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .vert      (vert),
      .pop       (pop),
      .push      (push),
      .push_data (push_data)
   );

   tavi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   tavi_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_row_index     (rsp_row_index),
      .rsp_inv_col0      (rsp_inv_col0),
      .rsp_inv_col1      (rsp_inv_col1),
      .rsp_inv_col2      (rsp_inv_col2),
      .rsp_offset        (rsp_offset),
      .rsp_signed_volume (rsp_signed_volume),
      .rsp_degenerate    (rsp_degenerate),
      .rsp_saturated     (rsp_saturated),
      .rsp_last          (rsp_last)
   );

   `TAVI_ASSERT_SAME(a_no_overfill, clock, reset, push, !q_status.full)
   `TAVI_ASSERT_NEXT(a_rows_contiguous, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   `TAVI_ASSERT_SAME(a_degenerate_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_inv_col0 == '0 && rsp_offset == '0 && rsp_signed_volume == '0 && !rsp_saturated)
endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the tetrahedron inverse block: every transaction's three response
// rows are predicted from exact integer arithmetic and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import tavi_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_t;
   typedef coord_t tetra_t [12];

   typedef struct {
      logic [ROW_W-1:0]            row;
      logic signed [OUT_WIDTH-1:0] col [3];
      logic signed [OUT_WIDTH-1:0] offset;
      logic signed [VOL_WIDTH-1:0] volume;
      logic                        degenerate;
      logic                        saturated;
      logic                        last;
   } inv_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_t req_c [12];
   logic rsp_valid;
   logic [ROW_W-1:0] rsp_row_index;
   logic signed [OUT_WIDTH-1:0] rsp_inv_col0, rsp_inv_col1, rsp_inv_col2, rsp_offset;
   logic signed [VOL_WIDTH-1:0] rsp_signed_volume;
   logic rsp_degenerate, rsp_saturated, rsp_last;

   inv_row_t expected_rows [$];
   int fail_count = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   initial foreach (req_c[i]) req_c[i] = '0;

   always #5 clock = ~clock;

   tetra_affine_inverse_and_volume uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_v0_x(req_c[0]), .req_v0_y(req_c[1]), .req_v0_z(req_c[2]),
      .req_v1_x(req_c[3]), .req_v1_y(req_c[4]), .req_v1_z(req_c[5]),
      .req_v2_x(req_c[6]), .req_v2_y(req_c[7]), .req_v2_z(req_c[8]),
      .req_v3_x(req_c[9]), .req_v3_y(req_c[10]), .req_v3_z(req_c[11]),
      .rsp_valid(rsp_valid), .rsp_row_index(rsp_row_index),
      .rsp_inv_col0(rsp_inv_col0), .rsp_inv_col1(rsp_inv_col1),
      .rsp_inv_col2(rsp_inv_col2), .rsp_offset(rsp_offset),
      .rsp_signed_volume(rsp_signed_volume), .rsp_degenerate(rsp_degenerate),
      .rsp_saturated(rsp_saturated), .rsp_last(rsp_last)
   );

   // signed round(num * 2^sh / den), ties away from zero, clamped to OUT_WIDTH
   function automatic logic [OUT_WIDTH-1:0] fixed_quotient(longint num, int sh,
                                                           longint den, inout bit sat);
      logic [127:0] n, d, q, r;
      logic [127:0] maxp;
      bit neg;
      maxp = (128'd1 << (OUT_WIDTH - 1)) - 1;
      if (num == 0) return '0;
      neg = (num < 0) != (den < 0);
      n = 128'(num < 0 ? -num : num) << sh;
      d = 128'(den < 0 ? -den : den);
      q = n / d;
      r = n % d;
      if (2 * r >= d) q = q + 1;
      if (neg) begin
         if (q > maxp + 1) begin
            q = maxp + 1;
            sat = 1'b1;
         end
         q = -q;
      end else if (q > maxp) begin
         q = maxp;
         sat = 1'b1;
      end
      return q[OUT_WIDTH-1:0];
   endfunction

   function automatic void predict_rows(tetra_t t);
      longint v [4][3];
      longint e [3][3];
      longint adj [3][3];
      longint det, vol, bn, vmax, vmin;
      bit volsat;
      bit sat;
      inv_row_t o;
      vmax = (longint'(1) << (VOL_WIDTH - 1)) - 1;
      vmin = -(longint'(1) << (VOL_WIDTH - 1));
      volsat = 1'b0;
      for (int p = 0; p < 4; p++)
         for (int c = 0; c < 3; c++) v[p][c] = t[p * 3 + c];
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) e[r][c] = v[c + 1][r] - v[0][r];
      adj[0][0] = e[1][1] * e[2][2] - e[1][2] * e[2][1];
      adj[0][1] = e[0][2] * e[2][1] - e[0][1] * e[2][2];
      adj[0][2] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
      adj[1][0] = e[1][2] * e[2][0] - e[1][0] * e[2][2];
      adj[1][1] = e[0][0] * e[2][2] - e[0][2] * e[2][0];
      adj[1][2] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
      adj[2][0] = e[1][0] * e[2][1] - e[1][1] * e[2][0];
      adj[2][1] = e[0][1] * e[2][0] - e[0][0] * e[2][1];
      adj[2][2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      det = e[0][0] * adj[0][0] + e[0][1] * adj[1][0] + e[0][2] * adj[2][0];
      vol = det / 6;
      if (vol > vmax) begin vol = vmax; volsat = 1'b1; end
      if (vol < vmin) begin vol = vmin; volsat = 1'b1; end
      for (int i = 0; i < 3; i++) begin
         sat = 1'b0;
         o.row = ROW_W'(i);
         o.last = (o.row == ROW_LAST);
         if (det == 0) begin
            foreach (o.col[j]) o.col[j] = '0;
            o.offset = '0;
            o.volume = '0;
            o.degenerate = 1'b1;
            o.saturated = 1'b0;
         end else begin
            bn = -(adj[i][0] * v[0][0] + adj[i][1] * v[0][1] + adj[i][2] * v[0][2]);
            for (int j = 0; j < 3; j++)
               o.col[j] = fixed_quotient(adj[i][j], A_SHIFT, det, sat);
            o.offset = fixed_quotient(bn, OUT_FRAC, det, sat);
            o.volume = vol[VOL_WIDTH-1:0];
            o.degenerate = 1'b0;
            o.saturated = sat || volsat;
         end
         expected_rows.push_back(o);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      inv_row_t w;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("unexpected row", rsp_row_index, 0);
         end else begin
            w = expected_rows.pop_front();
            if (rsp_row_index !== w.row) report_mismatch("row_index", rsp_row_index, w.row);
            if (rsp_inv_col0 !== w.col[0]) report_mismatch("inv_col0", rsp_inv_col0, w.col[0]);
            if (rsp_inv_col1 !== w.col[1]) report_mismatch("inv_col1", rsp_inv_col1, w.col[1]);
            if (rsp_inv_col2 !== w.col[2]) report_mismatch("inv_col2", rsp_inv_col2, w.col[2]);
            if (rsp_offset !== w.offset) report_mismatch("offset", rsp_offset, w.offset);
            if (rsp_signed_volume !== w.volume)
               report_mismatch("signed_volume", rsp_signed_volume, w.volume);
            if (rsp_degenerate !== w.degenerate)
               report_mismatch("degenerate", rsp_degenerate, w.degenerate);
            if (rsp_saturated !== w.saturated)
               report_mismatch("saturated", rsp_saturated, w.saturated);
            if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 300000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one transaction: held until start && !busy, then maybe an idle gap
   task automatic send_tetra(tetra_t t);
      foreach (req_c[i]) req_c[i] <= t[i];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_rows(t);
      if (!steady && $urandom_range(99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   function automatic tetra_t make_tetra(int a0, a1, a2, b0, b1, b2,
                                         c0, c1, c2, d0, d1, d2);
      tetra_t t;
      t = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
            coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2), coord_t'(d0),
            coord_t'(d1), coord_t'(d2)};
      return t;
   endfunction

   task automatic test_directed();
      // unit tetrahedron, mirrored one (negative det), offset origin
      send_tetra(make_tetra(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256));
      send_tetra(make_tetra(0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256));
      send_tetra(make_tetra(512, -768, 100, 1024, -768, 100, 512, 0, 100, 512, -768, 900));
      // all zero and repeated vertex: degenerate
      send_tetra(make_tetra(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_tetra(make_tetra(5, 6, 7, 5, 6, 7, 100, 3, 9, -40, 2, 8));
      // coplanar
      send_tetra(make_tetra(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0));
      // smallest tetrahedra: inverse stays in range; the far corner's offset clamps
      send_tetra(make_tetra(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_tetra(make_tetra(0, 0, 0, -1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_tetra(make_tetra(-32768, -32768, -32768, -32767, -32768, -32768,
                            -32768, -32767, -32768, -32768, -32768, -32767));
      // coordinate extremes, largest edges
      send_tetra(make_tetra(-32768, -32768, -32768, 32767, -32768, -32768,
                            -32768, 32767, -32768, -32768, -32768, 32767));
      send_tetra(make_tetra(32767, 32767, 32767, -32768, 32767, 32767,
                            32767, -32768, 32767, 32767, 32767, -32768));
      send_tetra(make_tetra(32767, -32768, 32767, -32768, 32767, -32768,
                            32767, 32767, -32768, -32768, -32768, 32767));
      // rounding: det 3 and det 30, with inexact quotients
      send_tetra(make_tetra(0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 0, 1));
      send_tetra(make_tetra(7, -3, 11, 10, -3, 11, 7, 2, 11, 7, -3, 13));
      // large offset with small inverse
      send_tetra(make_tetra(32767, -32768, 32767, 0, -32768, 32767,
                            32767, 0, 32767, 32767, -32768, 0));
      send_tetra(make_tetra(-32768, 32767, -32768, -32000, 32767, -32768,
                            -32768, 32000, -32768, -32768, 32767, -32000));
   endtask

   task automatic test_random_full(int n);
      tetra_t t;
      repeat (n) begin
         foreach (t[i]) t[i] = coord_t'($urandom);
         send_tetra(t);
      end
   endtask

   // small coordinates: tiny determinants, saturation and near-degenerate shapes
   task automatic test_random_small(int n);
      tetra_t t;
      int span;
      repeat (n) begin
         span = $urandom_range(1, 3) == 1 ? 2 : 40;
         foreach (t[i]) t[i] = coord_t'($urandom_range(0, 2 * span) - span);
         send_tetra(t);
      end
   endtask

   task automatic test_random_degenerate(int n);
      tetra_t t;
      int k;
      repeat (n) begin
         for (int i = 0; i < 9; i++) t[i] = coord_t'($urandom_range(0, 16000) - 8000);
         k = $urandom_range(0, 2);
         for (int c = 0; c < 3; c++) begin
            case (k)
               0: t[9 + c] = t[3 + c] + t[6 + c] - t[c];
               1: t[9 + c] = t[3 + c];
               default: t[9 + c] = t[c];
            endcase
         end
         send_tetra(t);
      end
   endtask

   task automatic drain_pause();
      start <= 1'b0;
      @(posedge clock);
      wait (expected_rows.size() == 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_full(150);
      drain_pause();
      steady = 1'b1;
      test_random_full(60);
      steady = 1'b0;
      test_random_small(130);
      test_random_degenerate(50);
      drain_pause();
      test_random_full(40);
      start <= 1'b0;
      wait (expected_rows.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_rows.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
